### design/fsd_pkg.sv
// Shared types, constants and arithmetic helpers of the error diffusion ditherer.
package fsd_pkg;

  localparam int DEF_MAX_WIDTH = 4096;

  // Field and register widths
  localparam int PIX_W    = 8;
  localparam int IVL_W    = 8;
  localparam int IMGW_W   = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W    = 11;   // stored error sums
  localparam int ERR_W    = 10;   // quantization error, signed
  localparam int PROD_W   = 13;   // error times weight
  localparam int SUM_W    = 13;   // pixel plus diffused error, signed
  localparam int NUM_W    = 10;   // rounding numerator 2*sum+interval

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

  // Reset values
  localparam logic [IVL_W-1:0]  RST_INTERVAL_LEN = 8'd85;
  localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH  = 13'd640;

  // Restoring divider: one numerator bit per step
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic load;      // take the input beat, apply frame/row restart
    logic sum;       // form clamped sum, set up divider
    logic div_step;  // one restoring division step
    logic update;    // commit quantized pixel, spread error, load output
    logic tail;      // flush last column to the line, start next row
  } fsd_cmd_t;

  typedef struct packed {
    logic has_right;
  } fsd_status_t;

  // Signed divide by 16, truncating toward zero
  function automatic logic signed [ACC_W-1:0] div16_tz(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] b;
    b = x + (x[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    b = b >>> 4;
    return b[ACC_W-1:0];
  endfunction

endpackage

### design/fsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fsd_ctrl.sv
// Sequencer of the ditherer: steps one pixel through read, sum, divide and commit.
module fsd_ctrl import fsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  fsd_status_t status,
  output fsd_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_SUM;
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = status.has_right ? S_IDLE : S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.sum) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/fsd_dp.sv
// Datapath of the ditherer: configuration, error carries, line buffer, quantizer.
module fsd_dp import fsd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [PIX_W-1:0]     gray_in,
  input  logic [PIX_W-1:0]     alpha_in,
  input  logic                 start_of_frame,
  output logic [PIX_W-1:0]     gray_out,
  output logic [PIX_W-1:0]     alpha_out,
  input  fsd_cmd_t             cmd,
  output fsd_status_t          status
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

  // Configuration
  logic [IVL_W-1:0]  interval_len;
  logic [IMGW_W-1:0] image_width;
  logic              has_alpha;

  // Pixel state
  logic [COL_W-1:0]        col;
  logic                    first_row;
  logic signed [ACC_W-1:0] carry;
  logic signed [ACC_W-1:0] pend0;
  logic signed [ACC_W-1:0] pend1;
  logic [PIX_W-1:0]        gray_r;
  logic [PIX_W-1:0]        alpha_r;
  logic [PIX_W-1:0]        sum_r;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        rem;

  // Line buffer port
  logic                    ram_we;
  logic [COL_W-1:0]        ram_waddr;
  logic [ACC_W-1:0]        ram_wdata;
  logic [ACC_W-1:0]        ram_rdata;

  logic [IVL_W-1:0]        iv;
  logic [WCNT_W-1:0]       w_eff;
  logic [31:0]             w_tmp;
  logic                    has_right;
  logic                    past_end;

  logic signed [SUM_W-1:0] sum_full;
  logic [PIX_W-1:0]        sum_clamp;
  logic [NUM_W-1:0]        n_val;
  logic [NUM_W-1:0]        d_val;
  logic [NUM_W-1:0]        rem_sh;
  logic [NUM_W-1:0]        q_diff;
  logic [PIX_W-1:0]        outv;
  logic signed [ERR_W-1:0] err;
  logic signed [PROD_W-1:0] err_x;
  logic signed [ACC_W-1:0] t1;
  logic signed [ACC_W-1:0] t3;
  logic signed [ACC_W-1:0] t5;
  logic signed [ACC_W-1:0] t7;

  // Effective interval and width
  assign iv = (interval_len == '0) ? IVL_W'(1) : interval_len;

  always_comb begin
    w_tmp = 32'(image_width);
    if (w_tmp == 32'd0) begin
      w_tmp = 32'd1;
    end
    if (w_tmp > 32'(MAX_WIDTH)) begin
      w_tmp = 32'(MAX_WIDTH);
    end
    w_eff = w_tmp[WCNT_W-1:0];
  end

  assign has_right        = (WCNT_W'(col) + WCNT_W'(1)) < w_eff;
  assign past_end         = WCNT_W'(col) >= w_eff;
  assign status.has_right = has_right;

  // Sum of pixel and diffused error, clamped to the pixel range
  always_comb begin
    sum_full = SUM_W'(signed'({1'b0, gray_r})) + SUM_W'(carry);
    if (!first_row) begin
      sum_full = sum_full + SUM_W'(signed'(ram_rdata));
    end
    if (sum_full < 0) begin
      sum_clamp = '0;
    end else if (sum_full > SUM_W'(signed'({1'b0, PIX_MAX}))) begin
      sum_clamp = PIX_MAX;
    end else begin
      sum_clamp = sum_full[PIX_W-1:0];
    end
  end

  // Rounding division: level = (2*sum + iv) / (2*iv); level*iv = (n - rem) / 2
  assign n_val  = {1'b0, sum_r, 1'b0} + NUM_W'(iv);
  assign d_val  = {1'b0, iv, 1'b0};
  assign rem_sh = {rem[NUM_W-2:0], num[NUM_W-1]};
  assign q_diff = n_val - rem;
  assign outv   = (q_diff[NUM_W-1:1] > {1'b0, PIX_MAX}) ? PIX_MAX : q_diff[PIX_W:1];

  assign err   = ERR_W'(signed'({2'b0, sum_r})) - ERR_W'(signed'({2'b0, outv}));
  assign err_x = PROD_W'(err);
  assign t1    = div16_tz(err_x);
  assign t3    = div16_tz(err_x * PROD_W'(3));
  assign t5    = div16_tz(err_x * PROD_W'(5));
  assign t7    = div16_tz(err_x * PROD_W'(7));

  // Line buffer writes: column left of the pixel on commit, last column on tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col;
    ram_wdata = ACC_W'(pend0);
    if (cmd.update && col != '0) begin
      ram_we    = 1'b1;
      ram_waddr = col - COL_W'(1);
      ram_wdata = ACC_W'(pend0 + t3);
    end else if (cmd.tail) begin
      ram_we = 1'b1;
    end
  end

  fsd_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_len <= RST_INTERVAL_LEN;
      image_width  <= RST_IMAGE_WIDTH;
      has_alpha    <= 1'b0;
      col          <= '0;
      first_row    <= 1'b1;
      carry        <= '0;
      pend0        <= '0;
      pend1        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_INTERVAL_LEN: interval_len <= cfg_data[IVL_W-1:0];
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMGW_W-1:0];
          REG_HAS_ALPHA:    has_alpha    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (start_of_frame || past_end) begin
          col       <= '0;
          carry     <= '0;
          pend0     <= '0;
          pend1     <= '0;
          first_row <= start_of_frame;
        end
      end
      if (cmd.update) begin
        pend0 <= pend1 + t5;
        pend1 <= has_right ? t1 : '0;
        carry <= has_right ? t7 : '0;
        if (has_right) begin
          col <= col + COL_W'(1);
        end
      end
      if (cmd.tail) begin
        col       <= '0;
        carry     <= '0;
        pend0     <= '0;
        pend1     <= '0;
        first_row <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gray_r  <= gray_in;
      alpha_r <= alpha_in;
    end
    if (cmd.sum) begin
      sum_r <= sum_clamp;
      rem   <= '0;
      num   <= {1'b0, sum_clamp, 1'b0} + NUM_W'(iv);
    end else if (cmd.div_step) begin
      num <= {num[NUM_W-2:0], 1'b0};
      if (rem_sh >= d_val) begin
        rem <= rem_sh - d_val;
      end else begin
        rem <= rem_sh;
      end
    end
    if (cmd.update) begin
      gray_out  <= outv;
      alpha_out <= has_alpha ? alpha_r : '0;
    end
  end

endmodule

### design/floyd_steinberg_ditherer.sv
// Top level of the Floyd-Steinberg error diffusion ditherer.
//
// Grayscale pixels enter in raster order on the input channel, one beat per
// pixel, and each gives one beat on the output channel: the pixel plus the
// error diffused to it, clamped to 0..255, rounded half away from zero to a
// multiple of interval_len and saturated at 255, with alpha copied through
// when has_alpha is set (else 0). Error goes 7/16 right, 3/16 below-left,
// 5/16 below and 1/16 below-right, each term truncated toward zero; terms
// outside the image are dropped. start_of_frame on a pixel restarts at the
// top-left corner. One pixel is worked on at a time: the next input beat is
// taken only after the line buffer read, the 10-step restoring divider that
// rounds to the interval and, on the last pixel of a row, the extra line
// buffer write that closes a row. A finished beat waits in the output
// register while the next pixel is accepted and worked on; the block
// stalls only when a second result is ready before the first is taken.
// Error for the next row lives in a single-port-write RAM of MAX_WIDTH
// entries; it needs no clearing after reset, since the first row of each
// frame ignores it. Write configuration (interval_len, image_width,
// has_alpha) only while the block is idle.
module floyd_steinberg_ditherer import fsd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     gray_in,
  input  logic [PIX_W-1:0]     alpha_in,
  input  logic                 start_of_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     gray_out,
  output logic [PIX_W-1:0]     alpha_out
);

  fsd_cmd_t    cmd;
  fsd_status_t status;

  // Sequencer: one pixel at a time, output beat held until taken
  fsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: registers, line buffer, quantizer and error spreading
  fsd_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .gray_in        (gray_in),
    .alpha_in       (alpha_in),
    .start_of_frame (start_of_frame),
    .gray_out       (gray_out),
    .alpha_out      (alpha_out),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

### design/fsd_checker.sv
// Port-level checks of the ditherer, bound to the top level.
module fsd_checker import fsd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_W-1:0]     gray_out,
  input logic [PIX_W-1:0]     alpha_out
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray_out) && $stable(alpha_out))
    else $error("stalled output beat changed");

  // An accepted pixel keeps the input not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  // A new result only appears while a pixel is in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no pixel in flight");

endmodule

bind floyd_steinberg_ditherer fsd_checker u_fsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .gray_out  (gray_out),
  .alpha_out (alpha_out)
);
